>>> src/ble_pkg.sv
package ble_pkg;

  // Default list capacity.
  localparam int CAPACITY_DEF = 16;

  // Request codes.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_REMOVE     = 3'd4;
  localparam logic [2:0] ACT_SEARCH     = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Cell update codes, broadcast along the row.
  localparam logic [1:0] COP_HOLD      = 2'd0;
  localparam logic [1:0] COP_INS_FRONT = 2'd1;
  localparam logic [1:0] COP_LOAD_AT   = 2'd2;
  localparam logic [1:0] COP_DROP_FROM = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] position;
    logic [4:0] count;
  } out_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

>>> src/ble_cell.sv
module ble_cell #(
  parameter int CAPACITY = ble_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                         clk,
  input  logic                         cmp_en,
  input  logic signed [31:0]           cmp_value,
  input  logic [$clog2(CAPACITY+1)-1:0] fill,
  input  ble_pkg::cell_ctrl_t          ctrl,
  input  logic [$clog2(CAPACITY)-1:0]  index,
  input  logic signed [31:0]           left_data,
  input  logic signed [31:0]           right_data,
  output logic signed [31:0]           data,
  output logic                         match
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [31:0] entry_r, entry_nxt;
  logic               match_r, match_nxt;
  logic               occupied;

  assign occupied = fill > CW'(IDX);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      ble_pkg::COP_INS_FRONT: entry_nxt = left_data;
      ble_pkg::COP_LOAD_AT: begin
        if (index == IW'(IDX)) entry_nxt = ctrl.value;
      end
      ble_pkg::COP_DROP_FROM: begin
        if (IW'(IDX) >= index) entry_nxt = right_data;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  assign match_nxt = cmp_en ? (occupied && (entry_r == cmp_value)) : match_r;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign data  = entry_r;
  assign match = match_r;

endmodule

>>> src/ble_pick.sv
module ble_pick #(
  parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
  input  logic [CAPACITY-1:0]         match,
  output logic                        found,
  output logic [$clog2(CAPACITY)-1:0] pos
);

  localparam int IW = $clog2(CAPACITY);

  logic [CAPACITY-1:0] lowest;

  // Isolate the match nearest the front, then encode it.
  assign lowest = match & (~match + CAPACITY'(1));
  assign found  = |match;

  always_comb begin
    pos = '0;
    for (int b = 0; b < IW; b++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (((i >> b) & 1) == 1) pos[b] = pos[b] | lowest[i];
      end
    end
  end

endmodule

>>> src/bounded_list_engine.sv
// Channel | Direction | Ports                          | Beat moves
// --------+-----------+--------------------------------+----------------------------
// in      | input     | in_valid, in_ready, in_data    | one request: action, value
// out     | output    | out_valid, out_ready, out_data | status, found, position, count
//
// Each request is handled in an accept step and an update step: at the accepting
// edge every cell compares its entry with the request value and registers a match
// bit; in the update state the priority picker's result steers the row of cells and
// the result is loaded. A new request is accepted only once the previous result is loaded.
// Reset clears the fill count, the state and the output valid; entries are not
// cleared, since only the first fill cells are ever compared or reported.
// When a result is still waiting, the update cycle stalls until it is taken.
module bounded_list_engine #(
  parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ble_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ble_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic               state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt, fill_upd;
  logic [2:0]         act_r;
  logic signed [31:0] val_r;
  logic               out_valid_r, out_valid_nxt;
  ble_pkg::out_t      out_data_r, out_data_nxt;

  logic               in_fire, exec_fire;
  logic [CAPACITY-1:0] match_w;
  logic signed [31:0] data_w [CAPACITY];
  logic               pick_found;
  logic [IW-1:0]      pick_pos;

  ble_pkg::cell_ctrl_t ctrl, ctrl_upd;
  logic [IW-1:0]       index_upd;
  logic [1:0]          status_upd;
  logic                found_upd;
  logic [IW-1:0]       pos_upd;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // The row of cells. Cell 0 takes the pushed value on an insert at the front;
  // the last cell keeps its own entry when the row shifts towards the front.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_left
      assign left_w = data_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = data_w[g];
    end else begin : g_right
      assign right_w = data_w[g+1];
    end
    ble_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk        (clk),
      .cmp_en     (in_fire),
      .cmp_value  (in_data.value),
      .fill       (fill_r),
      .ctrl       (ctrl),
      .index      (index_upd),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (data_w[g]),
      .match      (match_w[g])
    );
  end

  ble_pick #(
    .CAPACITY (CAPACITY)
  ) u_pick (
    .match (match_w),
    .found (pick_found),
    .pos   (pick_pos)
  );

  // Decode the held request against the fill count and the picked match.
  always_comb begin
    status_upd     = ble_pkg::ST_OK;
    found_upd      = 1'b0;
    pos_upd        = '0;
    fill_upd       = fill_r;
    index_upd      = '0;
    ctrl_upd.op    = ble_pkg::COP_HOLD;
    ctrl_upd.value = val_r;
    case (act_r)
      ble_pkg::ACT_PUSH_FRONT: begin
        if (fill_r == CW'(CAPACITY)) begin
          status_upd = ble_pkg::ST_FULL;
        end else begin
          ctrl_upd.op = ble_pkg::COP_INS_FRONT;
          fill_upd    = fill_r + CW'(1);
        end
      end
      ble_pkg::ACT_PUSH_BACK: begin
        if (fill_r == CW'(CAPACITY)) begin
          status_upd = ble_pkg::ST_FULL;
        end else begin
          ctrl_upd.op = ble_pkg::COP_LOAD_AT;
          index_upd   = fill_r[IW-1:0];
          fill_upd    = fill_r + CW'(1);
        end
      end
      ble_pkg::ACT_POP_FRONT: begin
        if (fill_r == '0) begin
          status_upd = ble_pkg::ST_EMPTY;
        end else begin
          ctrl_upd.op = ble_pkg::COP_DROP_FROM;
          fill_upd    = fill_r - CW'(1);
        end
      end
      ble_pkg::ACT_POP_BACK: begin
        if (fill_r == '0) status_upd = ble_pkg::ST_EMPTY;
        else fill_upd = fill_r - CW'(1);
      end
      ble_pkg::ACT_REMOVE, ble_pkg::ACT_SEARCH: begin
        if (!pick_found) begin
          status_upd = ble_pkg::ST_NOT_FOUND;
        end else begin
          found_upd = 1'b1;
          pos_upd   = pick_pos;
          if (act_r == ble_pkg::ACT_REMOVE) begin
            ctrl_upd.op = ble_pkg::COP_DROP_FROM;
            index_upd   = pick_pos;
            fill_upd    = fill_r - CW'(1);
          end
        end
      end
      default: begin
        status_upd = ble_pkg::ST_OK;
      end
    endcase
  end

  // Cells only move on the update cycle that actually delivers a result.
  always_comb begin
    ctrl = ctrl_upd;
    if (!exec_fire) ctrl.op = ble_pkg::COP_HOLD;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (in_fire) state_nxt = S_EXEC;
    if (exec_fire) begin
      state_nxt             = S_IDLE;
      fill_nxt              = fill_upd;
      out_valid_nxt         = 1'b1;
      out_data_nxt.status   = status_upd;
      out_data_nxt.found    = found_upd;
      out_data_nxt.position = 4'(pos_upd);
      out_data_nxt.count    = 5'(fill_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      act_r <= in_data.action;
      val_r <= in_data.value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The fill count never passes the capacity of the row.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // An accepted request always moves on to its update cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted request did not reach the update cycle");

  // A result only appears after an update cycle.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result raised without an update cycle");

  // The fill count only changes on the update cycle.
  a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_fire |=> $stable(fill_r))
    else $error("fill count changed outside an update cycle");

  // A reported match is always an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found) |-> (out_data_r.status == ble_pkg::ST_OK))
    else $error("match reported with a failing status");

endmodule
